/* sv/utf8e_pkg.sv */
`default_nettype none

package utf8e_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_TOO_LARGE = 3'd5
    } utf8e_status_t;

    localparam logic [7:0]  LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0]  LEAD_CONT_MAX  = 8'hBF;
    localparam logic [7:0]  LEAD_TWO_MAX   = 8'hDF;
    localparam logic [7:0]  LEAD_THREE_MAX = 8'hEF;
    localparam logic [7:0]  LEAD_FOUR_MAX  = 8'hF7;
    localparam logic [1:0]  CONT_TAG       = 2'b10;

    localparam logic [20:0] CP_ASCII_MAX   = 21'h00007F;
    localparam logic [20:0] CP_BMP_MAX     = 21'h00FFFF;
    localparam logic [20:0] CP_SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] CP_SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE   = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE   = 16'hDC00;

    localparam logic [7:0]  CH_BACKSLASH   = 8'h5C;
    localparam logic [7:0]  CH_U           = 8'h75;

    // index of the final character of a job
    localparam logic [3:0]  LAST_ONE       = 4'd0;
    localparam logic [3:0]  LAST_ESC       = 4'd5;
    localparam logic [3:0]  LAST_PAIR      = 4'd11;
    localparam logic [3:0]  ESC_LEN        = 4'd6;

    typedef struct packed {
        logic [3:0]    last_idx;
        logic [15:0]   val0;
        logic [15:0]   val1;
        utf8e_status_t status;
        logic          eos;
    } utf8e_job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/utf8e_decode.sv */
`default_nettype none

module utf8e_decode (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    input  wire  [7:0]             s_tdata,
    input  wire                    s_tlast,
    input  wire                    job_ready,
    output logic                   job_valid,
    output utf8e_pkg::utf8e_job_t  job
);
    import utf8e_pkg::*;

    logic [20:0]   acc_reg, acc_next;
    logic [1:0]    pend_reg, pend_next;
    logic [20:0]   cp;
    logic [20:0]   supp;
    logic          complete;
    utf8e_status_t status;
    logic          accept;

    assign accept = s_tvalid && job_ready;

    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        cp        = acc_reg;
        complete  = 1'b0;
        status    = ST_OK;
        if (pend_reg == 2'd0) begin
            if (s_tdata <= LEAD_ASCII_MAX) begin
                cp       = {13'd0, s_tdata};
                complete = 1'b1;
            end else if (s_tdata <= LEAD_CONT_MAX) begin
                status = ST_BAD_LEAD;
            end else if (s_tdata <= LEAD_TWO_MAX) begin
                acc_next  = {16'd0, s_tdata[4:0]};
                pend_next = 2'd1;
            end else if (s_tdata <= LEAD_THREE_MAX) begin
                acc_next  = {17'd0, s_tdata[3:0]};
                pend_next = 2'd2;
            end else if (s_tdata <= LEAD_FOUR_MAX) begin
                acc_next  = {18'd0, s_tdata[2:0]};
                pend_next = 2'd3;
            end else begin
                status = ST_BAD_LEAD;
            end
        end else begin
            if (s_tdata[7:6] != CONT_TAG) begin
                status = ST_BAD_CONT;
            end else begin
                cp        = {acc_reg[14:0], s_tdata[5:0]};
                acc_next  = cp;
                pend_next = pend_reg - 2'd1;
                complete  = (pend_reg == 2'd1);
            end
        end

        if (complete) begin
            acc_next = '0;
            if (cp >= CP_SURR_FIRST && cp <= CP_SURR_LAST) begin
                status = ST_SURROGATE;
            end else if (cp > CP_MAX) begin
                status = ST_TOO_LARGE;
            end
        end else if (status == ST_OK && s_tlast && pend_next != 2'd0) begin
            status = ST_TRUNCATED;
        end

        if (status != ST_OK) begin
            acc_next  = '0;
            pend_next = 2'd0;
        end
    end

    assign supp = cp - CP_SUPP_BASE;

    always_comb begin
        job.status   = status;
        job.eos      = s_tlast;
        job.last_idx = LAST_ONE;
        job.val0     = '0;
        job.val1     = '0;
        if (status == ST_OK) begin
            if (cp <= CP_ASCII_MAX) begin
                job.val0 = cp[15:0];
            end else if (cp <= CP_BMP_MAX) begin
                job.last_idx = LAST_ESC;
                job.val0     = cp[15:0];
            end else begin
                job.last_idx = LAST_PAIR;
                job.val0     = SURR_HI_BASE + {6'd0, supp[19:10]};
                job.val1     = SURR_LO_BASE | {6'd0, supp[9:0]};
            end
        end
    end

    assign job_valid = s_tvalid && (complete || status != ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= 2'd0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

/* sv/utf8e_emit.sv */
`default_nettype none

module utf8e_emit (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    job_valid,
    input  utf8e_pkg::utf8e_job_t  job,
    output logic                   job_ready,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic [3:0]             m_tuser
);
    import utf8e_pkg::*;

    utf8e_job_t  job_reg;
    logic        job_valid_reg;
    logic [3:0]  idx_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic [3:0]  m_tuser_reg;

    logic        out_free;
    logic        load;
    logic        job_last;
    logic        job_done;
    logic        half;
    logic [3:0]  pos;
    logic [15:0] val;
    logic [7:0]  char_next;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign load      = job_valid_reg && out_free;
    assign job_last  = (idx_reg == job_reg.last_idx);
    assign job_done  = load && job_last;
    assign job_ready = !job_valid_reg || job_done;

    // second escape of a pair starts at index six
    assign half = (idx_reg >= ESC_LEN);
    assign pos  = half ? (idx_reg - ESC_LEN) : idx_reg;
    assign val  = half ? job_reg.val1 : job_reg.val0;

    always_comb begin
        case (pos[2:0])
            3'd0:    char_next = CH_BACKSLASH;
            3'd1:    char_next = CH_U;
            3'd2:    char_next = hex_char(val[15:12]);
            3'd3:    char_next = hex_char(val[11:8]);
            3'd4:    char_next = hex_char(val[7:4]);
            3'd5:    char_next = hex_char(val[3:0]);
            default: char_next = 8'd0;
        endcase
        if (job_reg.status != ST_OK) begin
            char_next = 8'd0;
        end else if (job_reg.last_idx == LAST_ONE) begin
            char_next = job_reg.val0[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (job_ready && job_valid) begin
                job_valid_reg <= 1'b1;
                idx_reg       <= 4'd0;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
            end else if (load) begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            job_reg <= job;
        end
        if (load) begin
            m_tdata_reg <= char_next;
            m_tlast_reg <= job_last;
            m_tuser_reg <= {job_reg.status, job_last && job_reg.eos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* sv/utf8_to_utf16_escape.sv */
// utf8_to_utf16_escape: utf-8 bytes in, json-style ascii escape characters out
//
// input channel (s_): one utf-8 byte per word, s_tlast marks the last byte of
// a string. output channel (m_): one ascii character per word; m_tlast marks
// the last character caused by an input byte, m_tuser carries the string-done
// flag and a 3-bit status (0 ok, nonzero error; error words carry char 0).
// a byte gives 0 words while a sequence is open, 1 for ascii or an error,
// 6 for a \uXXXX escape and 12 for a surrogate pair.
//
// the first character of a byte passes the job register and then the
// character register before it is on m_tdata. throughput: one byte per
// cycle while each byte gives at most one word and the receiver does not
// stall; a byte giving more words holds the input while the single character
// register drains its pending escape one word per cycle when not stalled.
// when the receiver stalls, the current word holds, the pending job holds and
// s_tready stays low until the job can drain.
// reset (aresetn low, synchronous) empties both registers and returns the
// decoder to idle with a zero code point.
`default_nettype none

module utf8_to_utf16_escape (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // data_byte
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast,
    output logic [3:0] m_tuser    // status[2:0], string_done
);
    import utf8e_pkg::*;

    utf8e_job_t job;
    logic       job_valid;
    logic       job_ready;

    assign s_tready = job_ready;

    utf8e_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_ready (job_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    utf8e_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

/* sv/utf8e_checker.sv */
`default_nettype none

module utf8e_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast,
    input wire [3:0] m_tuser
);
    import utf8e_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // error words carry a zero char and close the run
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:1] != ST_OK |-> m_tdata == 8'd0 && m_tlast)
        else $error("error word malformed");

    // string done only on the last word of a run
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("string done without run end");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind utf8_to_utf16_escape utf8e_checker u_chk (.*);

`default_nettype wire
